// ----- rtl/fsol_pkg.sv -----
// types, constants and codes shared by the free list allocator
package fsol_pkg;

	localparam int OFFSET_W   = 24;
	localparam int COUNT_W    = 9;
	localparam int BYTES_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [BYTES_W-1:0]  MIN_SLOT_BYTES = BYTES_W'(8);
	localparam logic [OFFSET_W-1:0] OFFSET_MAX     = {OFFSET_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = CFG_IDX_W'(1);

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_ALLOCATED   = 3'd0,
		ST_FREED       = 3'd1,
		ST_EMPTY       = 3'd2,
		ST_BAD_OFFSET  = 3'd3,
		ST_NULL        = 3'd4,
		ST_DOUBLE_FREE = 3'd5
	} status_t;

	typedef struct packed {
		logic                mode;
		logic                no_pointer;
		logic [OFFSET_W-1:0] byte_offset;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [OFFSET_W-1:0] slot_offset;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_DISPATCH,
		S_ALLOC_WB,
		S_FRONT,
		S_WALK,
		S_INSERT
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_HEAD,
		RD_FOLLOW
	} rd_sel_t;

	typedef enum logic [2:0] {
		NXW_NONE,
		NXW_IDX_END,
		NXW_IDX_HEAD,
		NXW_CUR_IDX,
		NXW_IDX_RD
	} nxw_t;

	typedef enum logic [2:0] {
		PVW_NONE,
		PVW_IDX_END,
		PVW_HEAD_IDX,
		PVW_IDX_CUR,
		PVW_RD_IDX,
		PVW_RD_END
	} pvw_t;

	typedef enum logic [1:0] {
		HD_HOLD,
		HD_IDX,
		HD_RD
	} head_sel_t;

	typedef struct packed {
		logic      clr;
		logic      load_req;
		logic      div_start;
		logic      mul_en;
		rd_sel_t   rd;
		nxw_t      nx_wr;
		pvw_t      pv_wr;
		head_sel_t head;
		logic      empty_set;
		logic      empty_clr;
		logic      emit;
		status_t   status;
	} cmd_t;

	typedef struct packed {
		logic cfg_wr;
		logic clr_last;
		logic div_done;
		logic div_ok;
		logic mode;
		logic no_pointer;
		logic empty;
		logic idx_eq_head;
		logic idx_lt_head;
		logic rd_end;
		logic rd_ge_idx;
		logic rd_eq_idx;
	} sts_t;

endpackage

// ----- rtl/fixed_slot_ordered_free_list_core.sv -----
// top level of the fixed slot allocator with an address ordered free list
//
// request beat: taken on a rising edge with start high and busy low; req carries
// mode (allocate or free), the null pointer flag and the byte offset to free.
// result beat: done is high for exactly one cycle with rsp holding status and
// the allocated slot offset; the receiver cannot stall, so nothing waits.
// an allocate reads the next link memory at the head and loads the offset
// multiplier register in decode; the write back state then emits the result.
// a free first runs the bit serial offset divider, then the walk reads one
// next link a cycle from the link memory, so its time grows with the number
// of free slots below the offset.
// a null, misaligned, out of range or double free is answered as soon as found.
// configuration beat: cfg_valid with cfg_index and cfg_data, always ready;
// writing slot_count or slot_bytes rebuilds the pool with every slot free.
// after reset and after each such write a clearing pass rewrites every entry
// of both link memories; busy stays high throughout and no request is taken
// until it ends.
module fixed_slot_ordered_free_list_core #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  fsol_pkg::req_t                  req,
	output logic                            busy,
	output logic                            done,
	output fsol_pkg::rsp_t                  rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fsol_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsol_pkg::CFG_DATA_W-1:0] cfg_data
);

	fsol_pkg::cmd_t cmd;
	fsol_pkg::sts_t sts;
	logic           ctrl_busy;

	assign cfg_ready = 1'b1;

	fsol_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	fsol_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

	assign busy = ctrl_busy;

endmodule

// ----- rtl/fsol_div.sv -----
// restoring divider, one quotient bit per cycle, for offset by slot size
module fsol_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fsol_pkg::OFFSET_W-1:0] dividend,
	input  logic [fsol_pkg::BYTES_W-1:0]  divisor,
	output logic                         done,
	output logic [fsol_pkg::OFFSET_W-1:0] quo,
	output logic [fsol_pkg::BYTES_W-1:0]  rem
);

	localparam int CNT_W = $clog2(fsol_pkg::OFFSET_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(fsol_pkg::OFFSET_W - 1);

	logic                          run_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [fsol_pkg::OFFSET_W-1:0] quo_q;
	logic [fsol_pkg::BYTES_W-1:0]  rem_q;
	logic [fsol_pkg::BYTES_W:0]    trial;
	logic [fsol_pkg::BYTES_W:0]    div_ext;
	logic                          ge;

	assign trial   = {rem_q, quo_q[fsol_pkg::OFFSET_W-1]};
	assign div_ext = {1'b0, divisor};
	assign ge      = (trial >= div_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[fsol_pkg::OFFSET_W-2:0], ge};
			rem_q <= ge ? fsol_pkg::BYTES_W'(trial - div_ext) : fsol_pkg::BYTES_W'(trial);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/fsol_dp.sv -----
// datapath: configuration, link memories, head, divider, multiplier, result register
module fsol_dp #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [fsol_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsol_pkg::CFG_DATA_W-1:0] cfg_data,
	input  fsol_pkg::req_t                  req,
	input  fsol_pkg::cmd_t                  cmd,
	output fsol_pkg::sts_t                  sts,
	output logic                            done,
	output fsol_pkg::rsp_t                  rsp
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int LINK_W = $clog2(MAX_SLOTS + 1);
	localparam int ACC_W  = LINK_W + fsol_pkg::BYTES_W;
	localparam int PROD_W = IDX_W + fsol_pkg::BYTES_W;
	localparam logic [LINK_W-1:0] NO_LINK  = LINK_W'(MAX_SLOTS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SLOTS - 1);
	localparam logic [ACC_W-1:0]  ACC_MAX  = ACC_W'(fsol_pkg::OFFSET_MAX);

	logic [fsol_pkg::COUNT_W-1:0]  cfg_count_q;
	logic [fsol_pkg::BYTES_W-1:0]  cfg_bytes_q;
	logic [fsol_pkg::BYTES_W-1:0]  eff_bytes;
	logic [LINK_W-1:0]             n_eff;
	logic                          cfg_wr;

	logic [IDX_W-1:0]              head_q;
	logic                          empty_q;
	logic [IDX_W-1:0]              cur_q;
	logic [LINK_W-1:0]             rd_q;
	fsol_pkg::req_t                req_q;
	logic [fsol_pkg::OFFSET_W-1:0] prod_q;
	logic [IDX_W-1:0]              clr_q;
	logic [ACC_W-1:0]              acc_q;
	fsol_pkg::rsp_t                rsp_q;
	logic                          done_q;

	logic [LINK_W-1:0]             next_mem [MAX_SLOTS];
	logic [LINK_W-1:0]             prev_mem [MAX_SLOTS];

	logic                          div_done;
	logic [fsol_pkg::OFFSET_W-1:0] div_quo;
	logic [fsol_pkg::BYTES_W-1:0]  div_rem;
	logic [IDX_W-1:0]              idx;
	logic [LINK_W-1:0]             idx_link;

	logic [LINK_W-1:0]             clr_link;
	logic [LINK_W-1:0]             clr_plus;
	logic [ACC_W-1:0]              acc_plus;
	logic [LINK_W-1:0]             clr_next;
	logic [LINK_W-1:0]             clr_prev;

	logic                          nx_we;
	logic [IDX_W-1:0]              nx_waddr;
	logic [LINK_W-1:0]             nx_wdata;
	logic                          pv_we;
	logic [IDX_W-1:0]              pv_waddr;
	logic [LINK_W-1:0]             pv_wdata;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic [PROD_W-1:0]             prod_full;

	// effective configuration
	assign eff_bytes = (cfg_bytes_q < fsol_pkg::MIN_SLOT_BYTES) ?
		fsol_pkg::MIN_SLOT_BYTES : cfg_bytes_q;

	always_comb begin
		if (32'(cfg_count_q) > 32'(MAX_SLOTS)) begin
			n_eff = NO_LINK;
		end else if (cfg_count_q == '0) begin
			n_eff = LINK_W'(1);
		end else begin
			n_eff = LINK_W'(cfg_count_q);
		end
	end

	always_comb begin
		unique case (cfg_index)
			fsol_pkg::REG_SLOT_COUNT: cfg_wr = cfg_valid;
			fsol_pkg::REG_SLOT_BYTES: cfg_wr = cfg_valid;
			default:                  cfg_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= fsol_pkg::COUNT_W'(256);
			cfg_bytes_q <= fsol_pkg::MIN_SLOT_BYTES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fsol_pkg::REG_SLOT_COUNT: cfg_count_q <= cfg_data[fsol_pkg::COUNT_W-1:0];
				fsol_pkg::REG_SLOT_BYTES: cfg_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider for offset to slot number
	fsol_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (req_q.byte_offset),
		.divisor  (eff_bytes),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	assign idx      = IDX_W'(div_quo);
	assign idx_link = LINK_W'(idx);

	// rebuild values for the entry under the clearing pass
	assign clr_link = LINK_W'(clr_q);
	assign clr_plus = clr_link + LINK_W'(1);
	assign acc_plus = acc_q + ACC_W'(eff_bytes);
	assign clr_next = (clr_plus < n_eff && acc_plus <= ACC_MAX) ? clr_plus : NO_LINK;
	assign clr_prev = (clr_q != '0 && clr_link < n_eff && acc_q <= ACC_MAX) ?
		(clr_link - LINK_W'(1)) : NO_LINK;

	// next link write port
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = idx;
		nx_wdata = NO_LINK;
		if (cmd.clr) begin
			nx_we    = 1'b1;
			nx_waddr = clr_q;
			nx_wdata = clr_next;
		end else begin
			case (cmd.nx_wr)
				fsol_pkg::NXW_IDX_END: begin
					nx_we = 1'b1;
				end
				fsol_pkg::NXW_IDX_HEAD: begin
					nx_we    = 1'b1;
					nx_wdata = LINK_W'(head_q);
				end
				fsol_pkg::NXW_CUR_IDX: begin
					nx_we    = 1'b1;
					nx_waddr = cur_q;
					nx_wdata = idx_link;
				end
				fsol_pkg::NXW_IDX_RD: begin
					nx_we    = 1'b1;
					nx_wdata = rd_q;
				end
				default: ;
			endcase
		end
	end

	// previous link write port
	always_comb begin
		pv_we    = 1'b0;
		pv_waddr = idx;
		pv_wdata = NO_LINK;
		if (cmd.clr) begin
			pv_we    = 1'b1;
			pv_waddr = clr_q;
			pv_wdata = clr_prev;
		end else begin
			case (cmd.pv_wr)
				fsol_pkg::PVW_IDX_END: begin
					pv_we = 1'b1;
				end
				fsol_pkg::PVW_HEAD_IDX: begin
					pv_we    = 1'b1;
					pv_waddr = head_q;
					pv_wdata = idx_link;
				end
				fsol_pkg::PVW_IDX_CUR: begin
					pv_we    = 1'b1;
					pv_wdata = LINK_W'(cur_q);
				end
				fsol_pkg::PVW_RD_IDX: begin
					pv_we    = (rd_q < NO_LINK);
					pv_waddr = rd_q[IDX_W-1:0];
					pv_wdata = idx_link;
				end
				fsol_pkg::PVW_RD_END: begin
					pv_we    = 1'b1;
					pv_waddr = rd_q[IDX_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign rd_en   = (cmd.rd != fsol_pkg::RD_NONE);
	assign rd_addr = (cmd.rd == fsol_pkg::RD_HEAD) ? head_q : rd_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_waddr] <= nx_wdata;
		end
		if (rd_en) begin
			rd_q <= next_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_waddr] <= pv_wdata;
		end
	end

	// list head, clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			empty_q <= 1'b0;
			clr_q   <= '0;
			acc_q   <= '0;
		end else if (cfg_wr) begin
			head_q  <= '0;
			empty_q <= 1'b0;
			clr_q   <= '0;
			acc_q   <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + IDX_W'(1);
				acc_q <= acc_plus;
			end
			case (cmd.head)
				fsol_pkg::HD_IDX: head_q <= idx;
				fsol_pkg::HD_RD:  head_q <= rd_q[IDX_W-1:0];
				default: ;
			endcase
			if (cmd.empty_set) begin
				empty_q <= 1'b1;
			end else if (cmd.empty_clr) begin
				empty_q <= 1'b0;
			end
		end
	end

	assign prod_full = PROD_W'(head_q) * PROD_W'(eff_bytes);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.mul_en) begin
			prod_q <= fsol_pkg::OFFSET_W'(prod_full);
		end
		case (cmd.rd)
			fsol_pkg::RD_HEAD:   cur_q <= head_q;
			fsol_pkg::RD_FOLLOW: cur_q <= rd_q[IDX_W-1:0];
			default: ;
		endcase
		if (cmd.emit) begin
			rsp_q.status      <= cmd.status;
			rsp_q.slot_offset <= (cmd.status == fsol_pkg::ST_ALLOCATED) ? prod_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_comb begin
		sts.cfg_wr      = cfg_wr;
		sts.clr_last    = (clr_q == LAST_IDX);
		sts.div_done    = div_done;
		sts.div_ok      = (div_rem == '0) && (32'(div_quo) < 32'(n_eff));
		sts.mode        = req_q.mode;
		sts.no_pointer  = req_q.no_pointer;
		sts.empty       = empty_q;
		sts.idx_eq_head = (idx == head_q);
		sts.idx_lt_head = (idx < head_q);
		sts.rd_end      = (rd_q >= NO_LINK);
		sts.rd_ge_idx   = (rd_q >= idx_link);
		sts.rd_eq_idx   = (rd_q == idx_link);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/fsol_ctrl.sv -----
// controller state machine: clearing pass, request decode, list walk and insert
module fsol_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  fsol_pkg::sts_t sts,
	output fsol_pkg::cmd_t cmd,
	output logic           busy
);

	fsol_pkg::state_t state_q;
	fsol_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsol_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.clr       = 1'b0;
		cmd.load_req  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.mul_en    = 1'b0;
		cmd.rd        = fsol_pkg::RD_NONE;
		cmd.nx_wr     = fsol_pkg::NXW_NONE;
		cmd.pv_wr     = fsol_pkg::PVW_NONE;
		cmd.head      = fsol_pkg::HD_HOLD;
		cmd.empty_set = 1'b0;
		cmd.empty_clr = 1'b0;
		cmd.emit      = 1'b0;
		cmd.status    = fsol_pkg::ST_FREED;

		unique case (state_q)
			fsol_pkg::S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = fsol_pkg::S_IDLE;
				end
			end
			fsol_pkg::S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = fsol_pkg::S_DECODE;
				end
			end
			fsol_pkg::S_DECODE: begin
				if (sts.mode == fsol_pkg::MODE_ALLOC) begin
					if (sts.empty) begin
						cmd.emit   = 1'b1;
						cmd.status = fsol_pkg::ST_EMPTY;
						state_d    = fsol_pkg::S_IDLE;
					end else begin
						cmd.rd     = fsol_pkg::RD_HEAD;
						cmd.mul_en = 1'b1;
						state_d    = fsol_pkg::S_ALLOC_WB;
					end
				end else if (sts.no_pointer) begin
					cmd.emit   = 1'b1;
					cmd.status = fsol_pkg::ST_NULL;
					state_d    = fsol_pkg::S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = fsol_pkg::S_DIV;
				end
			end
			fsol_pkg::S_ALLOC_WB: begin
				if (sts.rd_end) begin
					cmd.empty_set = 1'b1;
				end else begin
					cmd.head  = fsol_pkg::HD_RD;
					cmd.pv_wr = fsol_pkg::PVW_RD_END;
				end
				cmd.emit   = 1'b1;
				cmd.status = fsol_pkg::ST_ALLOCATED;
				state_d    = fsol_pkg::S_IDLE;
			end
			fsol_pkg::S_DIV: begin
				if (sts.div_done) begin
					if (sts.div_ok) begin
						state_d = fsol_pkg::S_DISPATCH;
					end else begin
						cmd.emit   = 1'b1;
						cmd.status = fsol_pkg::ST_BAD_OFFSET;
						state_d    = fsol_pkg::S_IDLE;
					end
				end
			end
			fsol_pkg::S_DISPATCH: begin
				if (sts.empty) begin
					cmd.nx_wr     = fsol_pkg::NXW_IDX_END;
					cmd.pv_wr     = fsol_pkg::PVW_IDX_END;
					cmd.head      = fsol_pkg::HD_IDX;
					cmd.empty_clr = 1'b1;
					cmd.emit      = 1'b1;
					cmd.status    = fsol_pkg::ST_FREED;
					state_d       = fsol_pkg::S_IDLE;
				end else if (sts.idx_eq_head) begin
					cmd.emit   = 1'b1;
					cmd.status = fsol_pkg::ST_DOUBLE_FREE;
					state_d    = fsol_pkg::S_IDLE;
				end else if (sts.idx_lt_head) begin
					cmd.nx_wr = fsol_pkg::NXW_IDX_HEAD;
					cmd.pv_wr = fsol_pkg::PVW_IDX_END;
					state_d   = fsol_pkg::S_FRONT;
				end else begin
					cmd.rd  = fsol_pkg::RD_HEAD;
					state_d = fsol_pkg::S_WALK;
				end
			end
			fsol_pkg::S_FRONT: begin
				cmd.pv_wr  = fsol_pkg::PVW_HEAD_IDX;
				cmd.head   = fsol_pkg::HD_IDX;
				cmd.emit   = 1'b1;
				cmd.status = fsol_pkg::ST_FREED;
				state_d    = fsol_pkg::S_IDLE;
			end
			fsol_pkg::S_WALK: begin
				if (sts.rd_end || sts.rd_ge_idx) begin
					if (sts.rd_eq_idx) begin
						cmd.emit   = 1'b1;
						cmd.status = fsol_pkg::ST_DOUBLE_FREE;
						state_d    = fsol_pkg::S_IDLE;
					end else begin
						cmd.nx_wr = fsol_pkg::NXW_CUR_IDX;
						cmd.pv_wr = fsol_pkg::PVW_IDX_CUR;
						state_d   = fsol_pkg::S_INSERT;
					end
				end else begin
					cmd.rd = fsol_pkg::RD_FOLLOW;
				end
			end
			fsol_pkg::S_INSERT: begin
				cmd.nx_wr  = fsol_pkg::NXW_IDX_RD;
				cmd.pv_wr  = fsol_pkg::PVW_RD_IDX;
				cmd.emit   = 1'b1;
				cmd.status = fsol_pkg::ST_FREED;
				state_d    = fsol_pkg::S_IDLE;
			end
			default: begin
				state_d = fsol_pkg::S_CLEAR;
			end
		endcase

		// a register write rebuilds the pool
		if (sts.cfg_wr) begin
			state_d = fsol_pkg::S_CLEAR;
		end
	end

	assign busy = (state_q != fsol_pkg::S_IDLE);

endmodule

// ----- sim/tb_top.sv -----
// testbench for the fixed slot allocator: pool predictor, directed cases and random traffic
module tb_top;

	localparam int MAX_SLOTS   = 256;
	localparam int NO_LINK     = MAX_SLOTS;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 320;

	localparam logic [fsol_pkg::CFG_IDX_W-1:0] REG_SPARE_A = fsol_pkg::CFG_IDX_W'(2);
	localparam logic [fsol_pkg::CFG_IDX_W-1:0] REG_SPARE_B = fsol_pkg::CFG_IDX_W'(3);

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            start     = 1'b0;
	fsol_pkg::req_t                  req       = '0;
	logic                            busy;
	logic                            done;
	fsol_pkg::rsp_t                  rsp;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fsol_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fsol_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// shadow of the pool
	int unsigned fwd [MAX_SLOTS];
	bit          taken [MAX_SLOTS];
	int unsigned first_free;
	bit          none_free;
	int unsigned count_reg = 256;
	int unsigned bytes_reg = 8;

	fsol_pkg::rsp_t owed_results[$];
	int   errors       = 0;
	int   quiet_cycles = 0;
	int   idle_pct     = 0;
	int   alloc_pct    = 40;

	fixed_slot_ordered_free_list_core #(.MAX_SLOTS(MAX_SLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slot_size();
		return (bytes_reg < 8) ? 8 : bytes_reg;
	endfunction

	function automatic int unsigned live_slots();
		int unsigned n;
		int unsigned fit;
		n = count_reg;
		fit = 24'hFFFFFF / slot_size() + 1;
		if (n < 1) n = 1;
		if (n > MAX_SLOTS) n = MAX_SLOTS;
		if (n > fit) n = fit;
		return n;
	endfunction

	function automatic void rebuild_pool();
		int unsigned n;
		n = live_slots();
		for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
			fwd[i] = (i + 1 < n) ? i + 1 : NO_LINK;
			taken[i] = 1'b0;
		end
		first_free = 0;
		none_free = 1'b0;
	endfunction

	function automatic fsol_pkg::req_t make_req(logic m, logic nul,
		logic [fsol_pkg::OFFSET_W-1:0] off);
		fsol_pkg::req_t r;
		r.mode = m;
		r.no_pointer = nul;
		r.byte_offset = off;
		return r;
	endfunction

	// updates the shadow pool and returns the answer the block owes
	function automatic fsol_pkg::rsp_t allocator_outcome(fsol_pkg::req_t r);
		int unsigned bsz;
		int unsigned n;
		int unsigned idx;
		int unsigned cur;
		int unsigned nx;
		fsol_pkg::rsp_t o;
		bsz = slot_size();
		n = live_slots();
		o.status = fsol_pkg::ST_FREED;
		o.slot_offset = '0;
		if (r.mode == fsol_pkg::MODE_ALLOC) begin
			if (none_free || first_free >= MAX_SLOTS) begin
				o.status = fsol_pkg::ST_EMPTY;
			end else begin
				idx = first_free;
				nx = fwd[idx];
				if (nx >= MAX_SLOTS) none_free = 1'b1;
				else first_free = nx;
				taken[idx] = 1'b1;
				o.status = fsol_pkg::ST_ALLOCATED;
				o.slot_offset = fsol_pkg::OFFSET_W'(idx * bsz);
			end
		end else if (r.no_pointer) begin
			o.status = fsol_pkg::ST_NULL;
		end else if (r.byte_offset % bsz != 0 || r.byte_offset / bsz >= n) begin
			o.status = fsol_pkg::ST_BAD_OFFSET;
		end else begin
			idx = r.byte_offset / bsz;
			if (none_free || first_free >= MAX_SLOTS) begin
				first_free = idx;
				fwd[idx] = NO_LINK;
				none_free = 1'b0;
				taken[idx] = 1'b0;
			end else if (idx == first_free) begin
				o.status = fsol_pkg::ST_DOUBLE_FREE;
			end else if (idx < first_free) begin
				fwd[idx] = first_free;
				first_free = idx;
				taken[idx] = 1'b0;
			end else begin
				cur = first_free;
				for (int unsigned s = 0; s < MAX_SLOTS; s++) begin
					nx = fwd[cur];
					if (nx >= MAX_SLOTS || nx >= idx) break;
					cur = nx;
				end
				nx = fwd[cur];
				if (nx == idx) begin
					o.status = fsol_pkg::ST_DOUBLE_FREE;
				end else begin
					fwd[cur] = idx;
					fwd[idx] = (nx < MAX_SLOTS) ? nx : NO_LINK;
					taken[idx] = 1'b0;
				end
			end
		end
		return o;
	endfunction

	function automatic fsol_pkg::req_t random_item();
		int unsigned bsz;
		int unsigned n;
		int unsigned pick;
		int unsigned used[$];
		int unsigned spare[$];
		fsol_pkg::req_t r;
		bsz = slot_size();
		n = live_slots();
		for (int unsigned i = 0; i < n; i++) begin
			if (taken[i]) used.push_back(i);
			else spare.push_back(i);
		end
		r.mode = fsol_pkg::MODE_FREE;
		r.no_pointer = 1'b0;
		r.byte_offset = fsol_pkg::OFFSET_W'($urandom);
		pick = $urandom_range(99);
		if (pick < alloc_pct || (pick < 75 && used.size() == 0)) begin
			r.mode = fsol_pkg::MODE_ALLOC;
			r.no_pointer = 1'($urandom);
		end else if (pick < 75) begin
			r.byte_offset = fsol_pkg::OFFSET_W'(used[$urandom_range(used.size() - 1)] * bsz);
		end else if (pick < 82 && spare.size() != 0) begin
			r.byte_offset = fsol_pkg::OFFSET_W'(spare[$urandom_range(spare.size() - 1)] * bsz);
		end else if (pick < 88) begin
			r.byte_offset = fsol_pkg::OFFSET_W'($urandom_range(n - 1) * bsz +
				$urandom_range(bsz - 1, 1));
		end else if (pick < 94) begin
			r.byte_offset = fsol_pkg::OFFSET_W'($urandom_range(24'hFFFFFF, n * bsz));
		end else begin
			r.no_pointer = 1'b1;
		end
		return r;
	endfunction

	// request beat: start stays high, the caller lowers it when it idles
	task automatic issue_request(input fsol_pkg::req_t item);
		start <= 1'b1;
		req <= item;
		do @(posedge clk); while (busy !== 1'b0);
		owed_results.push_back(allocator_outcome(item));
	endtask

	task automatic maybe_pause();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fsol_pkg::CFG_IDX_W-1:0] idx,
		input logic [fsol_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		if (idx == fsol_pkg::REG_SLOT_COUNT) begin
			count_reg = val & 16'h01FF;
			rebuild_pool();
		end else if (idx == fsol_pkg::REG_SLOT_BYTES) begin
			bytes_reg = val;
			rebuild_pool();
		end
		// wait out the clearing pass
		repeat (2) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic run_burst(input int unsigned items);
		repeat (items) begin
			maybe_pause();
			issue_request(random_item());
		end
	endtask

	task automatic test_small_pool_cases();
		idle_pct = 0;
		write_reg(fsol_pkg::REG_SLOT_COUNT, 16'hFE02);
		issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b1, 24'hFFFFFF));
		issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd8));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd8));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b1, 24'hFFFFFF));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd3));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd16));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'hFFFFFF));
	endtask

	task automatic test_ordered_insert();
		drain_results();
		write_reg(fsol_pkg::REG_SLOT_COUNT, 16'd4);
		write_reg(fsol_pkg::REG_SLOT_BYTES, 16'd12);
		repeat (3) issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b1, 24'h800000));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd36));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd12));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd24));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd24));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd36));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_ALLOC, 1'b0, 24'd0));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd48));
		issue_request(make_req(fsol_pkg::MODE_FREE, 1'b0, 24'd6));
	endtask

	task automatic test_register_extremes();
		drain_results();
		idle_pct = 14;
		alloc_pct = 40;
		write_reg(fsol_pkg::REG_SLOT_COUNT, 16'h0000);
		run_burst(15);
		drain_results();
		write_reg(fsol_pkg::REG_SLOT_BYTES, 16'hFFFF);
		run_burst(15);
		drain_results();
		write_reg(fsol_pkg::REG_SLOT_COUNT, 16'hFFFF);
		run_burst(20);
		// writes to unused indexes must leave the pool alone
		drain_results();
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h5A5A);
		run_burst(15);
		drain_results();
		write_reg(fsol_pkg::REG_SLOT_BYTES, 16'h0000);
		run_burst(15);
	endtask

	task automatic test_random_traffic();
		logic [fsol_pkg::CFG_DATA_W-1:0] cnt;
		logic [fsol_pkg::CFG_DATA_W-1:0] bsz;
		for (int k = 0; k < 8; k++) begin
			drain_results();
			case (k)
				0: begin cnt = 16'h0100; bsz = 16'h0008; end
				1: begin cnt = 16'h0010; bsz = 16'h000C; end
				2: begin cnt = 16'hFE05; bsz = 16'hFFFF; end
				3: begin cnt = 16'h0080; bsz = 16'h0000; end
				4: begin cnt = 16'h0001; bsz = 16'h0018; end
				5: begin cnt = 16'h0028; bsz = 16'h03E8; end
				6: begin cnt = 16'h01FF; bsz = 16'h0003; end
				default: begin cnt = 16'h00C8; bsz = 16'($urandom_range(300, 9)); end
			endcase
			write_reg(fsol_pkg::REG_SLOT_COUNT, cnt);
			write_reg(fsol_pkg::REG_SLOT_BYTES, bsz);
			case (k % 4)
				0: idle_pct = 0;
				1: idle_pct = 69;
				2: idle_pct = 0;
				default: idle_pct = 14;
			endcase
			alloc_pct = (k % 2 == 0) ? 60 : 40;
			run_burst(68);
		end
	endtask

	// result beat checker
	always @(posedge clk) begin : check_beat
		fsol_pkg::rsp_t want;
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d offset %0h",
					$time, rsp.status, rsp.slot_offset);
				errors++;
			end else begin
				want = owed_results.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					errors++;
				end
				if (rsp.slot_offset !== want.slot_offset) begin
					$display("%0t: slot_offset expected %0h actual %0h",
						$time, want.slot_offset, rsp.slot_offset);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
			else quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		rebuild_pool();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		test_small_pool_cases();
		test_ordered_insert();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
